// File: rtl/core/avr_pkg.sv
// types, widths and constants shared by the axis-angle rotation pipeline
`default_nettype none

package avr_pkg;

  // field widths
  localparam int VEC_W = 32;   // Q16.16 vector components
  localparam int AX_W  = 16;   // Q1.15 axis, sine, cosine

  // internal widths
  localparam int OC_W    = AX_W + 2;                 // 1 - cos, range 1..65536
  localparam int PROD_W  = 2 * AX_W;                 // axis*axis, axis*sine, Q2.30
  localparam int MUL_W   = 48;                       // oc*prod plus extra, Q.45
  localparam int COEF_W  = 32;                       // matrix coefficient, Q.28
  localparam int PR_W    = VEC_W + COEF_W;           // vector*coefficient, Q.44
  localparam int ACC_W   = PR_W + 2;                 // sum of three products
  localparam int OUT_SHIFT  = 28;
  localparam int RES_W      = ACC_W - OUT_SHIFT;     // rounded component before clipping
  localparam int COEF_SHIFT = 17;
  localparam int CC_SHIFT   = 30;                    // cosine scaled to Q.45
  localparam int SN_SHIFT   = 15;                    // axis*sine scaled to Q.45

  localparam int ONE_Q15 = 32768;

  localparam logic signed [MUL_W-1:0] COEF_RND = MUL_W'(1) << (COEF_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] OUT_RND  = ACC_W'(1) << (OUT_SHIFT - 1);

  localparam logic signed [VEC_W-1:0] ROT_MAX = {1'b0, {(VEC_W - 1){1'b1}}};
  localparam logic signed [VEC_W-1:0] ROT_MIN = {1'b1, {(VEC_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
    logic signed [AX_W-1:0]  axis_x;
    logic signed [AX_W-1:0]  axis_y;
    logic signed [AX_W-1:0]  axis_z;
    logic signed [AX_W-1:0]  sine;
    logic signed [AX_W-1:0]  cosine;
  } in_item_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;
    logic                    saturated;
  } out_item_t;

  // vector plus rotation matrix, m[row][col]
  typedef struct packed {
    logic signed [VEC_W-1:0]       vec_x;
    logic signed [VEC_W-1:0]       vec_y;
    logic signed [VEC_W-1:0]       vec_z;
    logic [2:0][2:0][COEF_W-1:0]   m;
  } coef_bus_t;

endpackage

`default_nettype wire

// File: rtl/core/avr_coef.sv
// three-stage rotation matrix generator: axis products, oc scaling, rounding
`default_nettype none

module avr_coef (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  avr_pkg::in_item_t   up_item,
  output logic                dn_valid,
  input  logic                dn_ready,
  output avr_pkg::coef_bus_t  dn_item
);

  logic [2:0] v_r;
  logic [2:0] adv;

  // stage a: axis products
  logic signed [avr_pkg::VEC_W-1:0]  vec_a_r [3];
  logic signed [avr_pkg::AX_W-1:0]   c_a_r;
  logic signed [avr_pkg::OC_W-1:0]   oc_a_r;
  logic signed [avr_pkg::PROD_W-1:0] sq_a_r [3];
  logic signed [avr_pkg::PROD_W-1:0] cr_a_r [3];   // product of the two other axes
  logic signed [avr_pkg::PROD_W-1:0] sn_a_r [3];
  logic signed [avr_pkg::OC_W-1:0]   oc_a_nxt;
  logic signed [avr_pkg::PROD_W-1:0] sq_a_nxt [3];
  logic signed [avr_pkg::PROD_W-1:0] cr_a_nxt [3];
  logic signed [avr_pkg::PROD_W-1:0] sn_a_nxt [3];

  // stage b: scaled by 1 - cos
  logic signed [avr_pkg::VEC_W-1:0]  vec_b_r [3];
  logic signed [avr_pkg::AX_W-1:0]   c_b_r;
  logic signed [avr_pkg::MUL_W-1:0]  tsq_b_r [3];
  logic signed [avr_pkg::MUL_W-1:0]  tcr_b_r [3];
  logic signed [avr_pkg::PROD_W-1:0] sn_b_r [3];
  logic signed [avr_pkg::MUL_W-1:0]  tsq_b_nxt [3];
  logic signed [avr_pkg::MUL_W-1:0]  tcr_b_nxt [3];

  // stage c: rounded coefficients
  avr_pkg::coef_bus_t coef_r;
  avr_pkg::coef_bus_t coef_nxt;

  function automatic logic [avr_pkg::COEF_W-1:0] round_coef(
    input logic signed [avr_pkg::MUL_W-1:0] t,
    input logic signed [avr_pkg::MUL_W-1:0] extra
  );
    logic signed [avr_pkg::MUL_W-1:0] s;
    s = t + extra + avr_pkg::COEF_RND;
    return avr_pkg::COEF_W'(s >>> avr_pkg::COEF_SHIFT);
  endfunction

  assign adv[2]   = !v_r[2] || dn_ready;
  assign adv[1]   = !v_r[1] || adv[2];
  assign adv[0]   = !v_r[0] || adv[1];
  assign up_ready = adv[0];
  assign dn_valid = v_r[2];
  assign dn_item  = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= up_valid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
    end
  end

  always_comb begin
    logic signed [avr_pkg::AX_W-1:0] ax [3];
    ax[0] = up_item.axis_x;
    ax[1] = up_item.axis_y;
    ax[2] = up_item.axis_z;
    oc_a_nxt = avr_pkg::OC_W'(avr_pkg::ONE_Q15)
             - {{(avr_pkg::OC_W - avr_pkg::AX_W){up_item.cosine[avr_pkg::AX_W-1]}},
                up_item.cosine};
    for (int k = 0; k < 3; k++) begin
      sq_a_nxt[k] = ax[k] * ax[k];
      cr_a_nxt[k] = ax[(k + 1) % 3] * ax[(k + 2) % 3];
      sn_a_nxt[k] = ax[k] * up_item.sine;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      vec_a_r[0] <= up_item.vec_x;
      vec_a_r[1] <= up_item.vec_y;
      vec_a_r[2] <= up_item.vec_z;
      c_a_r      <= up_item.cosine;
      oc_a_r     <= oc_a_nxt;
      sq_a_r     <= sq_a_nxt;
      cr_a_r     <= cr_a_nxt;
      sn_a_r     <= sn_a_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tsq_b_nxt[k] = oc_a_r * sq_a_r[k];
      tcr_b_nxt[k] = oc_a_r * cr_a_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      vec_b_r <= vec_a_r;
      c_b_r   <= c_a_r;
      sn_b_r  <= sn_a_r;
      tsq_b_r <= tsq_b_nxt;
      tcr_b_r <= tcr_b_nxt;
    end
  end

  always_comb begin
    logic signed [avr_pkg::MUL_W-1:0] cc;
    logic signed [avr_pkg::MUL_W-1:0] sx [3];
    cc = avr_pkg::MUL_W'(c_b_r) <<< avr_pkg::CC_SHIFT;
    for (int k = 0; k < 3; k++) begin
      sx[k] = avr_pkg::MUL_W'(sn_b_r[k]) <<< avr_pkg::SN_SHIFT;
    end
    coef_nxt.vec_x = vec_b_r[0];
    coef_nxt.vec_y = vec_b_r[1];
    coef_nxt.vec_z = vec_b_r[2];
    // diagonal, then above and below the diagonal
    coef_nxt.m[0][0] = round_coef(tsq_b_r[0], cc);
    coef_nxt.m[1][1] = round_coef(tsq_b_r[1], cc);
    coef_nxt.m[2][2] = round_coef(tsq_b_r[2], cc);
    coef_nxt.m[0][1] = round_coef(tcr_b_r[2], sx[2]);
    coef_nxt.m[1][0] = round_coef(tcr_b_r[2], -sx[2]);
    coef_nxt.m[1][2] = round_coef(tcr_b_r[0], sx[0]);
    coef_nxt.m[2][1] = round_coef(tcr_b_r[0], -sx[0]);
    coef_nxt.m[2][0] = round_coef(tcr_b_r[1], sx[1]);
    coef_nxt.m[0][2] = round_coef(tcr_b_r[1], -sx[1]);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      coef_r <= coef_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/avr_mac.sv
// three-stage matrix-vector product: products, row sums, rounding and clipping
`default_nettype none

module avr_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  avr_pkg::coef_bus_t  up_item,
  output logic                dn_valid,
  input  logic                dn_ready,
  output avr_pkg::out_item_t  dn_item
);

  logic [2:0] v_r;
  logic [2:0] adv;

  logic signed [avr_pkg::PR_W-1:0]  pr_a_r  [3][3];
  logic signed [avr_pkg::PR_W-1:0]  pr_a_nxt [3][3];
  logic signed [avr_pkg::ACC_W-1:0] acc_b_r [3];
  logic signed [avr_pkg::ACC_W-1:0] acc_b_nxt [3];
  avr_pkg::out_item_t               out_r;
  avr_pkg::out_item_t               out_nxt;

  assign adv[2]   = !v_r[2] || dn_ready;
  assign adv[1]   = !v_r[1] || adv[2];
  assign adv[0]   = !v_r[0] || adv[1];
  assign up_ready = adv[0];
  assign dn_valid = v_r[2];
  assign dn_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= up_valid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
    end
  end

  always_comb begin
    logic signed [avr_pkg::VEC_W-1:0] v [3];
    v[0] = up_item.vec_x;
    v[1] = up_item.vec_y;
    v[2] = up_item.vec_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr_a_nxt[i][j] = v[j] * $signed(up_item.m[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pr_a_r <= pr_a_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_b_nxt[i] = avr_pkg::ACC_W'(pr_a_r[i][0]) + avr_pkg::ACC_W'(pr_a_r[i][1])
                   + avr_pkg::ACC_W'(pr_a_r[i][2]) + avr_pkg::OUT_RND;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      acc_b_r <= acc_b_nxt;
    end
  end

  always_comb begin
    logic signed [avr_pkg::RES_W-1:0] r;
    logic signed [avr_pkg::VEC_W-1:0] rot [3];
    logic                             sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r = avr_pkg::RES_W'(acc_b_r[i] >>> avr_pkg::OUT_SHIFT);
      if (r > avr_pkg::RES_W'(avr_pkg::ROT_MAX)) begin
        rot[i] = avr_pkg::ROT_MAX;
        sat    = 1'b1;
      end else if (r < avr_pkg::RES_W'(avr_pkg::ROT_MIN)) begin
        rot[i] = avr_pkg::ROT_MIN;
        sat    = 1'b1;
      end else begin
        rot[i] = avr_pkg::VEC_W'(r);
      end
    end
    out_nxt.rot_x     = rot[0];
    out_nxt.rot_y     = rot[1];
    out_nxt.rot_z     = rot[2];
    out_nxt.saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/axis_angle_vector_rotation.sv
// top level of the axis-angle (rodrigues) vector rotation pipeline
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall    avr_pkg::in_item_t   (vector, axis, sin, cos)
//   out      output     out_valid / out_stall  avr_pkg::out_item_t  (rotated vector, clip flag)
//
// one transfer per cycle sustained while out_stall is low; the data passes six register
// stages (axis products, 1-cos scaling, coefficient rounding, vector products,
// row sums, rounding and clipping); every multiply has a register behind it
// synchronous active-low reset clears the stage valid bits only
// each stage holds under stall only when full and blocked, so bubbles close up;
// in_stall rises only when all six stages are full and out_stall is high
`default_nettype none

module axis_angle_vector_rotation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  avr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output avr_pkg::out_item_t out_item
);

  // matrix generator to matrix-vector product
  logic               coef_valid;
  logic               coef_ready;
  avr_pkg::coef_bus_t coef_item;
  logic               in_ready;

  assign in_stall = !in_ready;

  // stages one to three: rotation matrix from axis, sine and cosine
  avr_coef u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_item),
    .dn_valid (coef_valid),
    .dn_ready (coef_ready),
    .dn_item  (coef_item)
  );

  // stages four to six: product, rounding to q16.16 and saturation
  avr_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (coef_valid),
    .up_ready (coef_ready),
    .up_item  (coef_item),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_item  (out_item)
  );

endmodule

`default_nettype wire

// File: rtl/core/avr_checker.sv
// port-level checks for the rotation pipeline, bound to the top level
`default_nettype none

module avr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  avr_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  avr_pkg::out_item_t out_item
);

  // a blocked result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("blocked result changed");

  // a stalled input transfer holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input changed");

  // input back-pressure only comes from a blocked output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // clip flag only with a component at a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |->
      out_item.rot_x == avr_pkg::ROT_MAX || out_item.rot_x == avr_pkg::ROT_MIN ||
      out_item.rot_y == avr_pkg::ROT_MAX || out_item.rot_y == avr_pkg::ROT_MIN ||
      out_item.rot_z == avr_pkg::ROT_MAX || out_item.rot_z == avr_pkg::ROT_MIN)
    else $error("clip flag without clipped component");

endmodule

bind axis_angle_vector_rotation avr_checker u_avr_checker (.*);

`default_nettype wire

// File: tb/sv/avr_rotation_checker.sv
// result checker for the axis-angle rotation block: predicts each rotation and compares
`default_nettype none

module avr_rotation_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  avr_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  avr_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  // wide enough for the unrounded row sums with margin
  typedef logic signed [71:0] wide_t;

  avr_pkg::out_item_t expected_rot_q[$];
  avr_pkg::out_item_t want;
  int                 errors = 0;
  int                 n_checked = 0;

  function automatic wide_t round_half_up(wide_t v, int sh);
    wide_t one;
    one = 1;
    return (v + (one <<< (sh - 1))) >>> sh;
  endfunction

  function automatic wide_t matrix_coef(wide_t oc, wide_t prod, wide_t extra);
    return round_half_up(oc * prod + extra, avr_pkg::COEF_SHIFT);
  endfunction

  function automatic avr_pkg::out_item_t rotate_vector(avr_pkg::in_item_t it);
    wide_t              vx, vy, vz, ax, ay, az, sn, cs;
    wide_t              oc, cc, xs, ys, zs, xy, yz, zx;
    wide_t              m [3][3];
    wide_t              row_sum [3];
    wide_t              r;
    logic [2:0][31:0]   comp;
    avr_pkg::out_item_t res;
    vx = signed'(it.vec_x);
    vy = signed'(it.vec_y);
    vz = signed'(it.vec_z);
    ax = signed'(it.axis_x);
    ay = signed'(it.axis_y);
    az = signed'(it.axis_z);
    sn = signed'(it.sine);
    cs = signed'(it.cosine);
    oc = avr_pkg::ONE_Q15 - cs;
    cc = cs <<< avr_pkg::CC_SHIFT;
    xs = (ax * sn) <<< avr_pkg::SN_SHIFT;
    ys = (ay * sn) <<< avr_pkg::SN_SHIFT;
    zs = (az * sn) <<< avr_pkg::SN_SHIFT;
    xy = ax * ay;
    yz = ay * az;
    zx = az * ax;
    m[0][0] = matrix_coef(oc, ax * ax, cc);
    m[0][1] = matrix_coef(oc, xy, zs);
    m[0][2] = matrix_coef(oc, zx, -ys);
    m[1][0] = matrix_coef(oc, xy, -zs);
    m[1][1] = matrix_coef(oc, ay * ay, cc);
    m[1][2] = matrix_coef(oc, yz, xs);
    m[2][0] = matrix_coef(oc, zx, ys);
    m[2][1] = matrix_coef(oc, yz, -xs);
    m[2][2] = matrix_coef(oc, az * az, cc);
    res = '0;
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = vx * m[i][0] + vy * m[i][1] + vz * m[i][2];
      r = round_half_up(row_sum[i], avr_pkg::OUT_SHIFT);
      if (r > avr_pkg::ROT_MAX) begin
        r = avr_pkg::ROT_MAX;
        res.saturated = 1'b1;
      end
      if (r < avr_pkg::ROT_MIN) begin
        r = avr_pkg::ROT_MIN;
        res.saturated = 1'b1;
      end
      comp[i] = r[31:0];
    end
    res.rot_x = comp[0];
    res.rot_y = comp[1];
    res.rot_z = comp[2];
    return res;
  endfunction

  task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // retire before predicting so a same-edge transfer pair stays in order
      if (out_valid && !out_stall) begin
        if (expected_rot_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
          errors++;
        end else begin
          want = expected_rot_q.pop_front();
          n_checked++;
          if (out_item.rot_x !== want.rot_x) report("rot_x", want.rot_x, out_item.rot_x);
          if (out_item.rot_y !== want.rot_y) report("rot_y", want.rot_y, out_item.rot_y);
          if (out_item.rot_z !== want.rot_z) report("rot_z", want.rot_z, out_item.rot_z);
          if (out_item.saturated !== want.saturated)
            report("saturated", 32'(want.saturated), 32'(out_item.saturated));
        end
      end
      if (in_valid && !in_stall) expected_rot_q.push_back(rotate_vector(in_item));
    end
    pending    <= expected_rot_q.size();
    fail_count <= errors;
    checked    <= n_checked;
  end

endmodule

`default_nettype wire

// File: tb/sv/axis_angle_vector_rotation_tb.sv
// top of the axis-angle rotation testbench: clock, reset, stimulus and verdict
`default_nettype none

module axis_angle_vector_rotation_tb;

  localparam int RAND_PER_PHASE = 177;     // three phases plus the directed set, about 550
  localparam int CYCLE_LIMIT    = 200000;  // far above the slowest stalled run
  localparam int DRAIN_CYCLES   = 12;      // margin after the last expected rotation is retired

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  avr_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  avr_pkg::out_item_t out_item;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // 4 time unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  axis_angle_vector_rotation uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  avr_rotation_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rotations still expected", cycles, pending);
      $display("axis_angle_vector_rotation_tb NOT OK");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle from the current phase's rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Q16.16 component biased toward the corners
  function automatic logic [31:0] pick_vec();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'($urandom_range(131071)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  // Q1.15 value biased toward the corners
  function automatic logic [15:0] pick_q15();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0;
      3:       return 16'($urandom_range(63)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic avr_pkg::in_item_t make_item(logic [31:0] vx, logic [31:0] vy,
                                                  logic [31:0] vz, logic [15:0] ax,
                                                  logic [15:0] ay, logic [15:0] az,
                                                  logic [15:0] sn, logic [15:0] cs);
    avr_pkg::in_item_t it;
    it.vec_x  = vx;
    it.vec_y  = vy;
    it.vec_z  = vz;
    it.axis_x = ax;
    it.axis_y = ay;
    it.axis_z = az;
    it.sine   = sn;
    it.cosine = cs;
    return it;
  endfunction

  // mostly true rotations (unit axis, matching sine and cosine) with a spread of
  // vector magnitudes; the rest is arbitrary field content with corner bias
  function automatic avr_pkg::in_item_t random_rotation();
    avr_pkg::in_item_t it;
    logic [15:0]       sg;
    int                sh;
    if ($urandom_range(3) == 0) begin
      return make_item(pick_vec(), pick_vec(), pick_vec(), pick_q15(), pick_q15(),
                       pick_q15(), pick_q15(), pick_q15());
    end
    sh = $urandom_range(20);
    it.vec_x = $signed($urandom) >>> sh;
    it.vec_y = $signed($urandom) >>> sh;
    it.vec_z = $signed($urandom) >>> sh;
    sg = $urandom_range(1) ? 16'd32767 : -16'sd32767;
    case ($urandom_range(5))
      0: {it.axis_x, it.axis_y, it.axis_z} = {sg, 16'd0, 16'd0};
      1: {it.axis_x, it.axis_y, it.axis_z} = {16'd0, sg, 16'd0};
      2: {it.axis_x, it.axis_y, it.axis_z} = {16'd0, 16'd0, sg};
      3: begin
        // body diagonal, 1/sqrt(3) each
        it.axis_x = $urandom_range(1) ? 16'd18919 : -16'sd18919;
        it.axis_y = $urandom_range(1) ? 16'd18919 : -16'sd18919;
        it.axis_z = $urandom_range(1) ? 16'd18919 : -16'sd18919;
      end
      4: {it.axis_x, it.axis_y, it.axis_z} = {16'd23170, -16'sd23170, 16'd0};
      default: {it.axis_x, it.axis_y, it.axis_z} = {pick_q15(), pick_q15(), pick_q15()};
    endcase
    case ($urandom_range(8))
      0: {it.sine, it.cosine} = {16'd0, 16'd32767};
      1: {it.sine, it.cosine} = {16'd32767, 16'd0};
      2: {it.sine, it.cosine} = {16'd23170, 16'd23170};
      3: {it.sine, it.cosine} = {-16'sd23170, 16'd23170};
      4: {it.sine, it.cosine} = {16'd16384, 16'd28378};
      5: {it.sine, it.cosine} = {16'd28378, -16'sd16384};
      6: {it.sine, it.cosine} = {16'd0, -16'sd32768};
      7: {it.sine, it.cosine} = {-16'sd32768, 16'd0};
      default: {it.sine, it.cosine} = {pick_q15(), pick_q15()};
    endcase
    return it;
  endfunction

  // present one vector, with random sender gaps in front, and hold it until taken
  task automatic send_vector(avr_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  initial begin
    int directed;
    in_valid  <= 1'b0;
    in_item   <= '0;
    out_stall <= 1'b0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first idling pattern: sender rarely idle, receiver mostly stalled
    send_idle_pct = 11;
    recv_idle_pct = 79;

    // all zero
    send_vector(make_item(0, 0, 0, 0, 0, 0, 0, 0));
    // identity about z
    send_vector(make_item(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000,
                          0, 0, 16'd32767, 0, 16'd32767));
    // quarter turns about each axis, both signs of sine
    send_vector(make_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          16'd32767, 0, 0, 16'd32767, 0));
    send_vector(make_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          0, 16'd32767, 0, 16'h8000, 0));
    send_vector(make_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          0, 0, 16'h8000, 16'd32767, 0));
    // half turn, largest one-minus-cosine
    send_vector(make_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                          16'd32767, 0, 0, 0, 16'h8000));
    send_vector(make_item(32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9,
                          16'd18919, 16'd18919, 16'd18919, 0, 16'h8000));
    // non-unit axis at its most negative: clipping high, then low
    send_vector(make_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          16'h8000, 16'h8000, 16'h8000, 0, 16'h8000));
    send_vector(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          16'h8000, 16'h8000, 16'h8000, 0, 16'h8000));
    // vector extremes under identity
    send_vector(make_item(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                          0, 0, 16'd32767, 0, 16'd32767));
    // every field at its top, then at its bottom
    send_vector(make_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_vector(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_vector(make_item(32'h0010_0000, 32'hfff0_0000, 32'h0000_0001,
                          16'h8000, 0, 0, 16'h8000, 0));
    // tiny components, eighth turn, then a twelfth turn: exercises round half up on the output
    send_vector(make_item(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
                          0, 0, 16'd32767, 16'd23170, 16'd23170));
    send_vector(make_item(32'h0000_8000, 32'hffff_8000, 32'h0000_4000,
                          16'd23170, 16'd23170, 0, 16'd16384, 16'd28378));
    // axis not unit length, sine and cosine of no single angle
    send_vector(make_item(32'h0abc_def0, 32'hf543_2100, 32'h0011_2233,
                          16'd100, -16'sd200, 16'd300, 16'd12345, -16'sd5000));
    send_vector(make_item(32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333,
                          16'h5555, 16'haaaa, 16'h3333, 16'hcccc, 16'h0f0f));
    directed = sent;

    // random part in three idling patterns: receiver-heavy, sender-heavy, none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 11; recv_idle_pct = 79; end
        1:       begin send_idle_pct = 79; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) send_vector(random_rotation());
    end
    in_valid <= 1'b0;

    // let the checker see the last transfer, then drain the pipeline
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d vectors (%0d directed, rest random) under three stall patterns",
             sent, directed);
    $display("checked %0d rotations, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("axis_angle_vector_rotation_tb OK");
    end else begin
      $display("axis_angle_vector_rotation_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/avr_pkg.sv
rtl/core/avr_coef.sv
rtl/core/avr_mac.sv
rtl/core/axis_angle_vector_rotation.sv
rtl/core/avr_checker.sv
tb/sv/avr_rotation_checker.sv
tb/sv/axis_angle_vector_rotation_tb.sv
